>>> src/uilr_pkg.sv
// ----------------------------------------------------------------------------
// uilr_pkg
// Shared types and constants of the serial image-load receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package uilr_pkg;

  // Request command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Result kinds
  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOAD_BASE  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_LENGTH = 2'd2;

  // Register reset values
  localparam logic [31:0] RESET_LOAD_BASE  = 32'd0;
  localparam logic [31:0] RESET_MIN_LENGTH = 32'd64;
  localparam logic [31:0] RESET_MAX_LENGTH = 32'd1048576;
  localparam logic [31:0] DEFAULT_BASE     = 32'h0008_0000;

  // Link bytes
  localparam logic [7:0] START_MARK = 8'h03;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_K     = 8'h4B;

  // Result sequence that one request leaves behind
  typedef enum logic [1:0] {
    BURST_START,   // three start marks
    BURST_REJECT,  // 'S','E' and three start marks
    BURST_OK,      // 'O','K'
    BURST_WRITE    // one memory write
  } burst_t;

endpackage : uilr_pkg

`default_nettype wire

>>> src/uilr_if.sv
// ----------------------------------------------------------------------------
// uilr_in_if / uilr_out_if
// Valid/ready channels of the image-load receiver: requests in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface uilr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface : uilr_in_if

interface uilr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [31:0] write_address;
  logic        image_done;
  logic        last;

  modport source (output valid, output kind, output data_byte, output write_address,
                  output image_done, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input write_address,
                  input image_done, input last, output ready);
endinterface : uilr_out_if

`default_nettype wire

>>> src/uart_image_load_receiver.sv
// ----------------------------------------------------------------------------
// uart_image_load_receiver
// Receiver side of a serial image-load handshake: start marks, length check,
// 'O','K' / 'S','E' answers, and one memory write per image byte.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                         handshake
//  -------  ---  ----------------------------------------------  -----------
//  req      in   cmd, rx_byte                                    valid/ready
//  res      out  kind, data_byte, write_address, image_done,     valid/ready
//                last
//  cfg      in   cfg_index, cfg_data                             cfg_we only
//
//  A request updates the handshake state in the cycle it is taken and loads a
//  result sequence register; results leave it one per cycle unless res stalls.
//  An image byte gives one result, so data streams at one byte per cycle too;
//  a start command gives three results, an accepted length two, a rejected
//  five. A new request is taken in the cycle the last result of the previous
//  one leaves. rst (synchronous) clears state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_image_load_receiver #(
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  uilr_in_if.sink                                  req,
  uilr_out_if.source                               res,
  input  wire logic                                cfg_we,
  input  wire logic [uilr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [31:0]                         cfg_data
);

  import uilr_pkg::*;

  // Width that holds both a 32-bit word and an address
  localparam int EXT_WIDTH = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_DATA
  } phase_t;

  // Configuration registers
  logic [31:0] load_base;
  logic [31:0] min_length;
  logic [31:0] max_length;

  // Handshake state
  phase_t                phase, phase_next;
  logic [1:0]            length_byte_count, length_byte_count_next;
  logic [31:0]           length_accum, length_accum_next;
  logic [31:0]           bytes_remaining, bytes_remaining_next;
  logic [ADDR_WIDTH-1:0] write_pointer, write_pointer_next;

  // Result sequence register
  logic        busy;
  burst_t      burst, burst_next;
  logic        burst_load;
  logic [2:0]  burst_idx;
  logic [7:0]  burst_data, burst_data_next;
  logic [31:0] burst_addr, burst_addr_next;
  logic        burst_done, burst_done_next;

  logic                 res_last;
  logic                 res_fire;
  logic                 req_fire;
  logic [31:0]          full_length;
  logic [31:0]          base_sel;
  logic [EXT_WIDTH-1:0] base_ext;
  logic [EXT_WIDTH-1:0] ptr_ext;

  // Take a request when no result waits or the final one leaves now
  assign res_fire  = res.valid && res.ready;
  assign req.ready = !busy || (res.ready && res_last);
  assign req_fire  = req.valid && req.ready;

  assign full_length = {req.rx_byte, length_accum[23:0]};
  assign base_sel    = (load_base != 32'd0) ? load_base : DEFAULT_BASE;
  assign base_ext    = EXT_WIDTH'(base_sel);
  assign ptr_ext     = EXT_WIDTH'(write_pointer);

  // Advance the handshake for one request
  always_comb begin
    phase_next             = phase;
    length_byte_count_next = length_byte_count;
    length_accum_next      = length_accum;
    bytes_remaining_next   = bytes_remaining;
    write_pointer_next     = write_pointer;
    burst_load             = 1'b0;
    burst_next             = BURST_START;
    burst_data_next        = req.rx_byte;
    burst_addr_next        = 32'd0;
    burst_done_next        = 1'b0;

    if (req.cmd == CMD_START) begin
      phase_next             = PH_LEN;
      length_byte_count_next = 2'd0;
      length_accum_next      = 32'd0;
      bytes_remaining_next   = 32'd0;
      write_pointer_next     = '0;
      burst_load             = 1'b1;
      burst_next             = BURST_START;
    end else begin
      case (phase)
        PH_LEN: begin
          length_byte_count_next = length_byte_count + 2'd1;
          unique case (length_byte_count)
            2'd0: length_accum_next[7:0]   = req.rx_byte;
            2'd1: length_accum_next[15:8]  = req.rx_byte;
            2'd2: length_accum_next[23:16] = req.rx_byte;
            2'd3: begin
              length_accum_next = 32'd0;
              burst_load        = 1'b1;
              if (full_length < min_length || full_length > max_length) begin
                burst_next = BURST_REJECT;
              end else begin
                burst_next           = BURST_OK;
                write_pointer_next   = base_ext[ADDR_WIDTH-1:0];
                bytes_remaining_next = full_length;
                phase_next           = (full_length != 32'd0) ? PH_DATA : PH_IDLE;
              end
            end
          endcase
        end
        PH_DATA: begin
          bytes_remaining_next = bytes_remaining - 32'd1;
          write_pointer_next   = write_pointer + ADDR_WIDTH'(1);
          burst_load           = 1'b1;
          burst_next           = BURST_WRITE;
          burst_addr_next      = ptr_ext[31:0];
          burst_done_next      = (bytes_remaining == 32'd1);
          if (bytes_remaining == 32'd1) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          // idle: drop the byte
        end
      endcase
    end
  end

  // Pick the current result out of the sequence
  always_comb begin
    res.kind          = KIND_TX;
    res.data_byte     = START_MARK;
    res.write_address = 32'd0;
    res.image_done    = 1'b0;
    res_last          = 1'b0;
    unique case (burst)
      BURST_START: begin
        res_last = (burst_idx == 3'd2);
      end
      BURST_REJECT: begin
        if (burst_idx == 3'd0) begin
          res.data_byte = CHAR_S;
        end else if (burst_idx == 3'd1) begin
          res.data_byte = CHAR_E;
        end
        res_last = (burst_idx == 3'd4);
      end
      BURST_OK: begin
        res.data_byte = (burst_idx == 3'd0) ? CHAR_O : CHAR_K;
        res_last      = (burst_idx == 3'd1);
      end
      BURST_WRITE: begin
        res.kind          = KIND_WRITE;
        res.data_byte     = burst_data;
        res.write_address = burst_addr;
        res.image_done    = burst_done;
        res_last          = 1'b1;
      end
    endcase
  end

  assign res.valid = busy;
  assign res.last  = res_last;

  // Hold configuration, handshake state and the result sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      load_base         <= RESET_LOAD_BASE;
      min_length        <= RESET_MIN_LENGTH;
      max_length        <= RESET_MAX_LENGTH;
      phase             <= PH_IDLE;
      length_byte_count <= 2'd0;
      length_accum      <= 32'd0;
      bytes_remaining   <= 32'd0;
      write_pointer     <= '0;
      busy              <= 1'b0;
      burst             <= BURST_START;
      burst_idx         <= 3'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOAD_BASE:  load_base  <= cfg_data;
          REG_MIN_LENGTH: min_length <= cfg_data;
          REG_MAX_LENGTH: max_length <= cfg_data;
          default: begin
            // unknown register: drop the write
          end
        endcase
      end

      if (req_fire) begin
        phase             <= phase_next;
        length_byte_count <= length_byte_count_next;
        length_accum      <= length_accum_next;
        bytes_remaining   <= bytes_remaining_next;
        write_pointer     <= write_pointer_next;
        busy              <= burst_load;
        burst_idx         <= 3'd0;
        if (burst_load) begin
          burst <= burst_next;
        end
      end else if (res_fire) begin
        if (res_last) begin
          busy <= 1'b0;
        end else begin
          burst_idx <= burst_idx + 3'd1;
        end
      end
    end
  end

  // Result payload of the sequence register
  always_ff @(posedge clk) begin
    if (req_fire && burst_load) begin
      burst_data <= burst_data_next;
      burst_addr <= burst_addr_next;
      burst_done <= burst_done_next;
    end
  end

endmodule : uart_image_load_receiver

`default_nettype wire
